[design/bhwm_pkg.sv]
package bhwm_pkg;

    // defaults for the top-level parameters
    localparam int PAT_MAX_DEF  = 64;
    localparam int TEXT_MAX_DEF = 65536;

    // fixed field widths
    localparam int SYM_W   = 8;
    localparam int DIST_W  = 6;
    localparam int INDEX_W = 16;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 4;

    typedef enum logic {
        OP_PATTERN = 1'b0,
        OP_TEXT    = 1'b1
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_cmd;

endpackage

[design/bhwm_front.sv]
module bhwm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic                        i_req_type,
    input  logic [bhwm_pkg::SYM_W-1:0]  i_symbol,
    input  logic                        i_last,
    output logic                        o_full,
    output logic                        o_q_push,
    input  logic                        i_q_full,
    output bhwm_pkg::t_cmd              o_q_cmd
);
    import bhwm_pkg::*;

    logic r_vld;
    logic n_vld;
    t_cmd r_cmd;
    logic accept;

    // input stage register, drains into the queue
    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_q_cmd  = r_cmd;

    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // classify the item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd.op     <= i_req_type ? OP_TEXT : OP_PATTERN;
            r_cmd.symbol <= i_symbol;
            r_cmd.last   <= i_last;
        end
    end

endmodule

[design/bhwm_queue.sv]
module bhwm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bhwm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_vld,
    output bhwm_pkg::t_cmd o_cmd
);
    import bhwm_pkg::*;

    localparam int QP_W = $clog2(Q_DEPTH);

    t_cmd              r_mem [Q_DEPTH];
    logic [QP_W-1:0]   r_wr_ptr;
    logic [QP_W-1:0]   r_rd_ptr;
    logic [QP_W:0]     r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == (QP_W+1)'(Q_DEPTH));
    assign o_vld   = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QP_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QP_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[design/bhwm_back.sv]
module bhwm_back #(
    parameter int PAT_MAX  = bhwm_pkg::PAT_MAX_DEF,
    parameter int TEXT_MAX = bhwm_pkg::TEXT_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_vld,
    input  bhwm_pkg::t_cmd                i_q_cmd,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_found,
    output logic [bhwm_pkg::DIST_W-1:0]   o_best_distance,
    output logic [bhwm_pkg::INDEX_W-1:0]  o_best_index,
    output logic                          o_overflow
);
    import bhwm_pkg::*;

    localparam int IDX_W  = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int CNT_W  = $clog2(PAT_MAX + 1);
    localparam int POS_W  = $clog2(TEXT_MAX + 1);
    localparam int WIDE_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CMP    = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    // control state
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_closed, n_closed;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [IDX_W-1:0]   r_wptr, n_wptr;
    logic [CNT_W-1:0]   r_best, n_best;
    logic [INDEX_W-1:0] r_start, n_start;
    logic               r_ovf, n_ovf;
    logic               r_out_vld, n_out_vld;
    logic               r_rd_vld;

    // window scan
    logic [CNT_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_ra, n_ra;
    logic [INDEX_W-1:0] r_cand, n_cand;
    logic [CNT_W-1:0]   r_diff, n_diff;
    logic               r_last, n_last;

    // stores
    logic [SYM_W-1:0]   r_pat_mem [PAT_MAX];
    logic [SYM_W-1:0]   r_txt_mem [PAT_MAX];
    logic [SYM_W-1:0]   r_pat_q;
    logic [SYM_W-1:0]   r_txt_q;

    // result register
    logic               r_o_found;
    logic [DIST_W-1:0]  r_o_dist;
    logic [INDEX_W-1:0] r_o_index;
    logic               r_o_ovf;

    logic               take;
    logic               load;
    logic               pat_we;
    logic [IDX_W-1:0]   pat_wa;
    logic               txt_we;
    logic [CNT_W-1:0]   e_cnt;
    logic [POS_W-1:0]   t_pos;
    logic [IDX_W-1:0]   t_wptr;
    logic [IDX_W:0]     ring_tmp;
    logic               mis;
    logic [CNT_W-1:0]   diff_fin;
    logic               res_found;

    function automatic logic [CNT_W-1:0] init_best(input logic [CNT_W-1:0] c);
        return (c == '0) ? '0 : c - CNT_W'(1);
    endfunction

    assign take    = (r_state == S_IDLE) && i_q_vld;
    assign o_q_pop = take;
    assign mis     = (r_pat_q != r_txt_q);
    assign diff_fin = r_diff + CNT_W'(mis);
    assign load    = (r_state == S_FINISH) && (!r_out_vld || i_pop);
    assign res_found = (r_cnt != '0) && (r_best < r_cnt - CNT_W'(1));

    assign e_cnt  = r_closed ? '0 : r_cnt;
    assign pat_wa = e_cnt[IDX_W-1:0];
    assign t_pos  = r_closed ? r_pos : '0;
    assign t_wptr = r_closed ? r_wptr : '0;

    // ring address of the oldest symbol in the window ending at t_wptr
    always_comb begin
        ring_tmp = {1'b0, t_wptr} + (IDX_W+1)'(PAT_MAX) - (IDX_W+1)'(r_cnt - CNT_W'(1));
        if (ring_tmp >= (IDX_W+1)'(PAT_MAX)) begin
            ring_tmp = ring_tmp - (IDX_W+1)'(PAT_MAX);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_closed  = r_closed;
        n_pos     = r_pos;
        n_wptr    = r_wptr;
        n_best    = r_best;
        n_start   = r_start;
        n_ovf     = r_ovf;
        n_j       = r_j;
        n_ra      = r_ra;
        n_cand    = r_cand;
        n_diff    = r_diff;
        n_last    = r_last;
        pat_we    = 1'b0;
        txt_we    = 1'b0;
        n_out_vld = r_out_vld;
        if (i_pop) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (take && i_q_cmd.op == OP_PATTERN) begin
                    // a pattern symbol after a closed pattern starts a new one
                    n_cnt = e_cnt;
                    if (e_cnt < CNT_W'(PAT_MAX)) begin
                        pat_we = 1'b1;
                        n_cnt  = e_cnt + CNT_W'(1);
                    end
                    n_closed = i_q_cmd.last;
                    n_pos    = '0;
                    n_wptr   = '0;
                    n_best   = init_best(n_cnt);
                    n_start  = '0;
                    n_ovf    = 1'b0;
                end else if (take) begin
                    // text closes an open pattern and starts from clean text state
                    n_closed = 1'b1;
                    n_pos    = t_pos;
                    n_wptr   = t_wptr;
                    n_best   = r_closed ? r_best : init_best(r_cnt);
                    n_start  = r_closed ? r_start : '0;
                    n_ovf    = r_closed ? r_ovf : 1'b0;
                    n_last   = i_q_cmd.last;
                    if (i_q_cmd.last) begin
                        n_state = S_FINISH;
                    end
                    if (t_pos == POS_W'(TEXT_MAX)) begin
                        n_ovf = 1'b1;
                    end else begin
                        txt_we = 1'b1;
                        n_pos  = t_pos + POS_W'(1);
                        n_wptr = (t_wptr == IDX_W'(PAT_MAX - 1)) ? '0 : t_wptr + IDX_W'(1);
                        if (r_cnt != '0 &&
                            WIDE_W'(t_pos) + WIDE_W'(1) >= WIDE_W'(r_cnt)) begin
                            n_j     = '0;
                            n_ra    = ring_tmp[IDX_W-1:0];
                            n_cand  = INDEX_W'(WIDE_W'(t_pos) + WIDE_W'(1) - WIDE_W'(r_cnt));
                            n_diff  = '0;
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_CMP: begin
                if (r_rd_vld) begin
                    n_diff = diff_fin;
                end
                n_j  = r_j + CNT_W'(1);
                n_ra = (r_ra == IDX_W'(PAT_MAX - 1)) ? '0 : r_ra + IDX_W'(1);
                if (r_j == r_cnt - CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // strict compare keeps the earliest window on a tie
                if (diff_fin < r_best) begin
                    n_best  = diff_fin;
                    n_start = r_cand;
                end
                n_state = r_last ? S_FINISH : S_IDLE;
            end
            S_FINISH: begin
                if (load) begin
                    n_out_vld = 1'b1;
                    n_pos     = '0;
                    n_wptr    = '0;
                    n_best    = init_best(r_cnt);
                    n_start   = '0;
                    n_ovf     = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_closed  <= 1'b0;
            r_pos     <= '0;
            r_wptr    <= '0;
            r_best    <= '0;
            r_start   <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_closed  <= n_closed;
            r_pos     <= n_pos;
            r_wptr    <= n_wptr;
            r_best    <= n_best;
            r_start   <= n_start;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
            r_rd_vld  <= (r_state == S_CMP);
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_ra   <= n_ra;
        r_cand <= n_cand;
        r_diff <= n_diff;
        r_last <= n_last;
        if (load) begin
            r_o_found <= res_found;
            r_o_dist  <= DIST_W'(r_best);
            r_o_index <= res_found ? r_start : '0;
            r_o_ovf   <= r_ovf;
        end
    end

    // pattern store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat_mem[pat_wa] <= i_q_cmd.symbol;
        end
        if (r_state == S_CMP) begin
            r_pat_q <= r_pat_mem[r_j[IDX_W-1:0]];
        end
    end

    // text ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (txt_we) begin
            r_txt_mem[t_wptr] <= i_q_cmd.symbol;
        end
        if (r_state == S_CMP) begin
            r_txt_q <= r_txt_mem[r_ra];
        end
    end

    assign o_empty         = !r_out_vld;
    assign o_found         = r_o_found;
    assign o_best_distance = r_o_dist;
    assign o_best_index    = r_o_index;
    assign o_overflow      = r_o_ovf;

endmodule

[design/best_hamming_window_match.sv]
// Best Hamming-distance window match. Pattern items (req_type 0) build a pattern of up to
// PAT_MAX bytes, the one marked last closes it; text items (req_type 1) then stream in, and
// every full window of pattern length L is scored by its mismatch count against the pattern.
// The smallest count below L - 1 and the start index of the earliest window reaching it are
// kept; the last text item produces one result (found, best_distance, best_index, overflow)
// and clears the text state while the pattern stays for the next text. A pattern item after
// a closed pattern starts a new pattern. Text past TEXT_MAX symbols only sets overflow.
// Flow: every item passes through the input register before the queue. A pattern item is
// stored as the back end takes it, as is a text item with no full window yet; any other text
// item is scored by scanning the window one symbol a cycle through the single read port of
// the pattern store and of the text ring, then a drain state waits out the registered read;
// a last text item goes on to load the result register, and stalls there for as long as the
// previous result is still waiting to be popped.
// A 4-deep queue behind the input register takes items while the back end is scanning.
module best_hamming_window_match #(
    parameter int PAT_MAX  = bhwm_pkg::PAT_MAX_DEF,
    parameter int TEXT_MAX = bhwm_pkg::TEXT_MAX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // item input, queue style
    input  logic                          push,
    output logic                          full,
    input  logic                          i_req_type,
    input  logic [bhwm_pkg::SYM_W-1:0]    i_symbol,
    input  logic                          i_last,
    // result output, queue style
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_found,
    output logic [bhwm_pkg::DIST_W-1:0]   o_best_distance,
    output logic [bhwm_pkg::INDEX_W-1:0]  o_best_index,
    output logic                          o_overflow
);
    import bhwm_pkg::*;

    // front to queue
    logic q_push;
    logic q_full;
    t_cmd q_in_cmd;
    // queue to back
    logic q_vld;
    logic q_pop;
    t_cmd q_out_cmd;

    // input register and item classification
    bhwm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_symbol   (i_symbol),
        .i_last     (i_last),
        .o_full     (full),
        .o_q_push   (q_push),
        .i_q_full   (q_full),
        .o_q_cmd    (q_in_cmd)
    );

    // decouples intake from the window scan
    bhwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_cmd   (q_out_cmd)
    );

    // pattern store, text ring, window scan and result register
    bhwm_back #(
        .PAT_MAX  (PAT_MAX),
        .TEXT_MAX (TEXT_MAX)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_vld         (q_vld),
        .i_q_cmd         (q_out_cmd),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_found         (o_found),
        .o_best_distance (o_best_distance),
        .o_best_index    (o_best_index),
        .o_overflow      (o_overflow)
    );

endmodule

[design/bhwm_checker.sv]
module bhwm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          i_req_type,
    input logic [bhwm_pkg::SYM_W-1:0]    i_symbol,
    input logic                          i_last,
    input logic                          empty,
    input logic                          pop,
    input logic                          o_found,
    input logic [bhwm_pkg::DIST_W-1:0]   o_best_distance,
    input logic [bhwm_pkg::INDEX_W-1:0]  o_best_index,
    input logic                          o_overflow
);

    // reset leaves no result and room for input
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("result or full flag after reset");

    // a waiting result holds until taken
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_found) && $stable(o_best_distance)
                              && $stable(o_best_index) && $stable(o_overflow)))
        else $error("result changed before pop");

    // no match means a zero index
    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_found) |-> (o_best_index == '0))
        else $error("nonzero index without a match");

    // a shown result carries no unknown bits
    a_result_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !$isunknown({o_found, o_best_distance, o_best_index, o_overflow}))
        else $error("unknown bits in a result");

endmodule

bind best_hamming_window_match bhwm_checker u_bhwm_checker (.*);

[bench/best_hamming_window_match_checker.sv]
`timescale 1ns / 1ps
module best_hamming_window_match_checker #(
    parameter int PAT_MAX  = bhwm_pkg::PAT_MAX_DEF,
    parameter int TEXT_MAX = bhwm_pkg::TEXT_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_full,
    input  logic                         i_req_type,
    input  logic [bhwm_pkg::SYM_W-1:0]   i_symbol,
    input  logic                         i_last,
    input  logic                         i_empty,
    input  logic                         i_pop,
    input  logic                         i_found,
    input  logic [bhwm_pkg::DIST_W-1:0]  i_best_distance,
    input  logic [bhwm_pkg::INDEX_W-1:0] i_best_index,
    input  logic                         i_overflow,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_compared
);
    import bhwm_pkg::*;

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic               found;
        logic [DIST_W-1:0]  distance;
        logic [INDEX_W-1:0] index;
        logic               overflow;
    } t_match;

    t_match           awaited_matches[$];
    t_match           oldest;
    logic [SYM_W-1:0] pattern_bytes [PAT_MAX];
    logic [SYM_W-1:0] text_ring [PAT_MAX];
    int unsigned      pattern_len;
    int unsigned      text_taken;
    int unsigned      best_diff;
    int unsigned      best_start;
    bit               pattern_done;
    bit               text_overflowed;
    int               fail_count = 0;
    int               pending = 0;
    int               compared = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_compared   = compared;

    task automatic report_mismatch(string what, longint want, longint got);
        if (fail_count < PRINT_LIMIT) begin
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        end
        fail_count++;
    endtask

    function automatic void clear_text_state();
        text_taken      = 0;
        best_diff       = (pattern_len != 0) ? pattern_len - 1 : 0;
        best_start      = 0;
        text_overflowed = 1'b0;
    endfunction

    // one text symbol into the ring, then score the window that ends on it
    function automatic void score_window(logic [SYM_W-1:0] sym);
        int unsigned start;
        int unsigned diff;
        if (text_taken >= TEXT_MAX) begin
            text_overflowed = 1'b1;
            return;
        end
        text_ring[text_taken % PAT_MAX] = sym;
        text_taken++;
        if (pattern_len == 0 || text_taken < pattern_len) begin
            return;
        end
        start = text_taken - pattern_len;
        diff  = 0;
        for (int unsigned j = 0; j < pattern_len; j++) begin
            if (text_ring[(start + j) % PAT_MAX] != pattern_bytes[j]) begin
                diff++;
            end
        end
        // strict compare keeps the earliest window on ties
        if (diff < best_diff) begin
            best_diff  = diff;
            best_start = start & 32'hFFFF;
        end
    endfunction

    function automatic void absorb_item(t_op op, logic [SYM_W-1:0] sym, logic lst);
        t_match m;
        bit     hit;
        if (op == OP_PATTERN) begin
            if (pattern_done) begin
                pattern_done = 1'b0;
                pattern_len  = 0;
            end
            if (pattern_len < PAT_MAX) begin
                pattern_bytes[pattern_len] = sym;
                pattern_len++;
            end
            if (lst) begin
                pattern_done = 1'b1;
            end
            clear_text_state();
            return;
        end
        // text on an open pattern closes it as it stands
        if (!pattern_done) begin
            pattern_done = 1'b1;
            clear_text_state();
        end
        score_window(sym);
        if (!lst) begin
            return;
        end
        hit        = pattern_len > 0 && best_diff < pattern_len - 1;
        m.found    = hit;
        m.distance = DIST_W'(best_diff);
        m.index    = hit ? INDEX_W'(best_start) : '0;
        m.overflow = text_overflowed;
        awaited_matches.push_back(m);
        clear_text_state();
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pattern_len  = 0;
            pattern_done = 1'b0;
            clear_text_state();
            awaited_matches.delete();
        end else begin
            // results first: nothing accepted at this edge can already be out
            if (i_pop && !i_empty) begin
                if (awaited_matches.size() == 0) begin
                    report_mismatch("result with nothing expected", 0, 0);
                end else begin
                    oldest = awaited_matches.pop_front();
                    compared++;
                    if (i_found !== oldest.found) begin
                        report_mismatch("found", oldest.found, i_found);
                    end
                    if (i_best_distance !== oldest.distance) begin
                        report_mismatch("best_distance", oldest.distance, i_best_distance);
                    end
                    if (i_best_index !== oldest.index) begin
                        report_mismatch("best_index", oldest.index, i_best_index);
                    end
                    if (i_overflow !== oldest.overflow) begin
                        report_mismatch("overflow", oldest.overflow, i_overflow);
                    end
                end
            end
            if (i_push && !i_full) begin
                absorb_item(t_op'(i_req_type), i_symbol, i_last);
            end
        end
        pending = awaited_matches.size();
    end

endmodule

[bench/best_hamming_window_match_test.sv]
`timescale 1ns / 1ps
module best_hamming_window_match_test;
    import bhwm_pkg::*;

    // run bounds: about 2000 items, a watchdog cycle limit and a settle time at the end
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int RANDOM_ITEMS   = 1950;
    localparam int SETTLE_CYCLES  = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic               i_req_type = 1'b0;
    logic [SYM_W-1:0]   i_symbol = '0;
    logic               i_last = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic               o_found;
    logic [DIST_W-1:0]  o_best_distance;
    logic [INDEX_W-1:0] o_best_index;
    logic               o_overflow;

    int fail_count;
    int pending_results;
    int compared_results;

    // no idle cycles on either side while set
    bit quiet = 1'b0;
    int items_sent = 0;
    int cycle_count = 0;

    // small alphabet per sequence so that close matches are common
    logic [SYM_W-1:0] letters [4];
    int               letter_count = 2;

    best_hamming_window_match dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_req_type      (i_req_type),
        .i_symbol        (i_symbol),
        .i_last          (i_last),
        .empty           (empty),
        .pop             (pop),
        .o_found         (o_found),
        .o_best_distance (o_best_distance),
        .o_best_index    (o_best_index),
        .o_overflow      (o_overflow)
    );

    best_hamming_window_match_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_full          (full),
        .i_req_type      (i_req_type),
        .i_symbol        (i_symbol),
        .i_last          (i_last),
        .i_empty         (empty),
        .i_pop           (pop),
        .i_found         (o_found),
        .i_best_distance (o_best_distance),
        .i_best_index    (o_best_index),
        .i_overflow      (o_overflow),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results),
        .o_compared      (compared_results)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("Mismatches found");
        $finish;
    end

    // result side: random stall before each pop, none while quiet
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 8);
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // drive one item after a random gap and hold it until it is taken;
    // push stays high on exit, the next call or a lower_push takes it down
    task automatic send_item(t_op op, logic [SYM_W-1:0] sym, logic lst);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push       <= 1'b1;
        i_req_type <= op;
        i_symbol   <= sym;
        i_last     <= lst;
        do @(posedge i_clk); while (full);
    endtask

    task automatic lower_push();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    // hold the input until every expected result has been popped
    task automatic drain_results();
        lower_push();
        while (pending_results != 0) @(negedge i_clk);
    endtask

    task automatic new_letters();
        letter_count = $urandom_range(2, 4);
        for (int i = 0; i < 4; i++) begin
            letters[i] = SYM_W'($urandom_range(0, 255));
        end
    endtask

    function automatic logic [SYM_W-1:0] pick_symbol(bit scramble);
        if (scramble) begin
            return SYM_W'($urandom_range(0, 255));
        end
        return letters[$urandom_range(0, letter_count - 1)];
    endfunction

    // symbols past the pattern store are dropped by the block and not counted
    task automatic send_pattern(int n, bit close, bit scramble);
        for (int i = 0; i < n; i++) begin
            send_item(OP_PATTERN, pick_symbol(scramble), close && i == n - 1);
            if (i < PAT_MAX_DEF) begin
                items_sent++;
            end
        end
    endtask

    task automatic send_text(int n, bit close, bit scramble);
        for (int i = 0; i < n; i++) begin
            send_item(OP_TEXT, pick_symbol(scramble), close && i == n - 1);
            items_sent++;
        end
    endtask

    // mostly short patterns, a few up to and past the store size
    function automatic int draw_pattern_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(1, 6);
        end else if (r < 85) begin
            return $urandom_range(7, 20);
        end else if (r < 95) begin
            return $urandom_range(21, 64);
        end
        return $urandom_range(64, 70);
    endfunction

    task automatic run_directed();
        // empty pattern: text right after reset closes a zero-length pattern
        send_item(OP_TEXT, 8'h00, 1'b1);
        // extreme bytes, best window is the second one
        send_item(OP_PATTERN, 8'h00, 1'b0);
        send_item(OP_PATTERN, 8'hFF, 1'b1);
        send_item(OP_TEXT, 8'hFF, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'hFF, 1'b1);
        // short text, no full window against the kept pattern
        send_item(OP_TEXT, 8'h80, 1'b1);
        // new pattern left open, text closes it; two exact windows, earliest wins
        send_item(OP_PATTERN, 8'h01, 1'b0);
        send_item(OP_PATTERN, 8'h7F, 1'b0);
        send_item(OP_TEXT, 8'h01, 1'b0);
        send_item(OP_TEXT, 8'h7F, 1'b0);
        send_item(OP_TEXT, 8'h01, 1'b0);
        send_item(OP_TEXT, 8'h7F, 1'b1);
        // new pattern after a closed one; tie at distance one keeps index 0
        send_item(OP_PATTERN, 8'hAA, 1'b0);
        send_item(OP_PATTERN, 8'h55, 1'b0);
        send_item(OP_PATTERN, 8'hF0, 1'b1);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'h55, 1'b0);
        send_item(OP_TEXT, 8'hF0, 1'b0);
        send_item(OP_TEXT, 8'hAA, 1'b0);
        send_item(OP_TEXT, 8'h00, 1'b0);
        send_item(OP_TEXT, 8'hF0, 1'b1);
        items_sent += 22;
    endtask

    // one random sequence; every kind begins with a pattern, so a text left
    // without its last mark is dropped by the next pattern
    task automatic run_random_sequence(int forced_len);
        int kind;
        int plen;
        int texts;
        int tlen;
        new_letters();
        quiet = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 11) == 0) begin
            drain_results();
        end
        kind = (forced_len > 0) ? 0 : $urandom_range(0, 9);
        plen = (forced_len > 0) ? forced_len : draw_pattern_len();
        if (kind < 7) begin
            // well-formed: closed pattern, then one to three texts against it
            send_pattern(plen, 1'b1, 1'b0);
            texts = $urandom_range(1, 3);
            for (int t = 0; t < texts; t++) begin
                if ($urandom_range(0, 99) < 15) begin
                    tlen = $urandom_range(1, (plen > 1) ? plen - 1 : 1);
                end else begin
                    tlen = $urandom_range(plen, plen + 12);
                end
                send_text(tlen, 1'b1, 1'b0);
            end
        end else if (kind == 7) begin
            // pattern never closed, the text closes it
            send_pattern($urandom_range(1, 5), 1'b0, 1'b0);
            send_text($urandom_range(1, 12), 1'b1, 1'b0);
        end else if (kind == 8) begin
            // text abandoned without its last mark
            send_pattern(plen, 1'b1, 1'b1);
            send_text($urandom_range(1, plen + 4), 1'b0, 1'b1);
        end else begin
            // unrelated random bytes
            send_pattern(plen, 1'b1, 1'b1);
            send_text($urandom_range(1, plen + 8), 1'b1, 1'b1);
        end
    endtask

    initial begin
        int random_start;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        // sender waits here until every directed result is out
        drain_results();

        // pattern store overrun: last on a dropped symbol, then a full store
        random_start = items_sent;
        run_random_sequence(67);
        run_random_sequence(PAT_MAX_DEF);
        while (items_sent - random_start < RANDOM_ITEMS) begin
            run_random_sequence(0);
        end

        // wind down: no more items, wait for the last results
        quiet = 1'b0;
        lower_push();
        while (pending_results != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d items: directed edge cases and random pattern/text sequences",
                 items_sent);
        $display("%0d results compared in %0d cycles", compared_results, cycle_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
